// ===== design/grm_pkg.sv =====
// Package for the geofence recovery monitor: widths, register map,
// reset values and the monitor mode type. No dependencies.
`timescale 1ns / 1ps

package grm_pkg;

  // Field widths
  localparam int COORD_WIDTH = 24;
  localparam int COUNT_WIDTH = 16;
  localparam int VTX_WIDTH   = 2 * COORD_WIDTH;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int NUM_EDGES   = 4;

  // Configuration port: 64-bit data, registers on 8-byte boundaries
  localparam int DATA_WIDTH  = 64;
  localparam int NUM_REGS    = 8;
  localparam int IDX_WIDTH   = $clog2(NUM_REGS);
  localparam int ADDR_LSB    = 3;
  localparam int ADDR_WIDTH  = IDX_WIDTH + ADDR_LSB;

  localparam logic [IDX_WIDTH-1:0] REG_VERTEX_0    = IDX_WIDTH'(0);
  localparam logic [IDX_WIDTH-1:0] REG_VERTEX_1    = IDX_WIDTH'(1);
  localparam logic [IDX_WIDTH-1:0] REG_VERTEX_2    = IDX_WIDTH'(2);
  localparam logic [IDX_WIDTH-1:0] REG_VERTEX_3    = IDX_WIDTH'(3);
  localparam logic [IDX_WIDTH-1:0] REG_HEIGHT_LOW  = IDX_WIDTH'(4);
  localparam logic [IDX_WIDTH-1:0] REG_HEIGHT_HIGH = IDX_WIDTH'(5);
  localparam logic [IDX_WIDTH-1:0] REG_STOP_WAIT   = IDX_WIDTH'(6);
  localparam logic [IDX_WIDTH-1:0] REG_SETTLE_WAIT = IDX_WIDTH'(7);

  // Reset values
  localparam logic signed [COORD_WIDTH-1:0] HEIGHT_LOW_RST  = COORD_WIDTH'(-1000);
  localparam logic signed [COORD_WIDTH-1:0] HEIGHT_HIGH_RST = COORD_WIDTH'(1000);
  localparam logic [COUNT_WIDTH-1:0]        STOP_WAIT_RST   = COUNT_WIDTH'(50);
  localparam logic [COUNT_WIDTH-1:0]        SETTLE_WAIT_RST = COUNT_WIDTH'(70);
  localparam logic [COUNT_WIDTH-1:0]        COUNT_MAX       = '1;

  // Monitor mode, as reported on the result word
  typedef enum logic [1:0] {
    MODE_ACTIVE  = 2'd0,
    MODE_OOB     = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

endpackage

// ===== design/geofence_recovery_monitor.sv =====
// Geofence recovery monitor top level: pose register, cross-product stage,
// monitor state update and result register. Depends on grm_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one word per pose tick. A word is taken at a rising
//   edge with in_valid high and in_stall low. Every word advances the force
//   latch and the stop timer; only words with in_pose_valid high yield a
//   result word.
//   Result channel (out_*): mode after the tick, stop/start pulses and the
//   geometric outside flag. A word is taken when out_valid is high and
//   out_stall is low; while stalled the word holds.
//   Configuration (APB): eight registers at byte address 8*i, 64-bit data,
//   write only while the block is idle. pready is tied high.
// Pipeline and flow
//   An input word passes the pose register and then the product register,
//   and the state update loads its result into the result register. One word
//   per cycle is sustained while the result channel is not stalled; the loop
//   through the monitor state sits in the last stage.
//   Each stage frees itself whenever the next one can take its word, so a
//   new input word is still taken while a finished result waits; in_stall
//   rises only once every stage holds a word behind a stalled result.
// Reset
//   rst_n (synchronous, active low) empties the pipeline, returns to ACTIVE,
//   clears the force latch and both counters, and loads the register reset
//   values (all vertices at the origin, z in [-1000, 1000], waits 50 / 70).
module geofence_recovery_monitor
  import grm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pose_valid,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic                          in_force_request,
  input  logic                          in_odometry_running,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_mode,
  output logic                          out_stop_odometry,
  output logic                          out_start_odometry,
  output logic                          out_outside,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_WIDTH-1:0]         paddr,
  input  logic [DATA_WIDTH-1:0]         pwdata,
  output logic [DATA_WIDTH-1:0]         prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [VTX_WIDTH-1:0]          vtx_r [NUM_EDGES];
  logic signed [COORD_WIDTH-1:0] h_low_r;
  logic signed [COORD_WIDTH-1:0] h_high_r;
  logic [COUNT_WIDTH-1:0]        stop_wait_r;
  logic [COUNT_WIDTH-1:0]        settle_wait_r;

  logic                 cfg_wr;
  logic [IDX_WIDTH-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_WIDTH-1:ADDR_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        vtx_r[i] <= '0;
      end
      h_low_r       <= HEIGHT_LOW_RST;
      h_high_r      <= HEIGHT_HIGH_RST;
      stop_wait_r   <= STOP_WAIT_RST;
      settle_wait_r <= SETTLE_WAIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VERTEX_0, REG_VERTEX_1, REG_VERTEX_2, REG_VERTEX_3: begin
          vtx_r[cfg_idx[1:0]] <= pwdata[VTX_WIDTH-1:0];
        end
        REG_HEIGHT_LOW:  h_low_r       <= pwdata[COORD_WIDTH-1:0];
        REG_HEIGHT_HIGH: h_high_r      <= pwdata[COORD_WIDTH-1:0];
        REG_STOP_WAIT:   stop_wait_r   <= pwdata[COUNT_WIDTH-1:0];
        REG_SETTLE_WAIT: settle_wait_r <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended to the bus width
  always_comb begin
    case (cfg_idx)
      REG_VERTEX_0, REG_VERTEX_1, REG_VERTEX_2, REG_VERTEX_3: begin
        prdata = DATA_WIDTH'(vtx_r[cfg_idx[1:0]]);
      end
      REG_HEIGHT_LOW:  prdata = DATA_WIDTH'($unsigned(h_low_r));
      REG_HEIGHT_HIGH: prdata = DATA_WIDTH'($unsigned(h_high_r));
      REG_STOP_WAIT:   prdata = DATA_WIDTH'(stop_wait_r);
      REG_SETTLE_WAIT: prdata = DATA_WIDTH'(settle_wait_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  //   stage 1: pose register, stage 2: product register, then result.
  //   A word without a valid pose leaves stage 2 without a result slot.
  // ---------------------------------------------------------------------
  logic v1_r, v2_r, out_valid_r;
  logic pv2_r;
  logic out_free, take2, free2, free1, load1;

  assign out_free = !out_valid_r || !out_stall;
  assign take2    = v2_r && (!pv2_r || out_free);
  assign free2    = !v2_r || take2;
  assign free1    = !v1_r || free2;
  assign in_stall = !free1;
  assign load1    = in_valid && free1;

  // ---------------------------------------------------------------------
  // Stage 1: pose register
  // ---------------------------------------------------------------------
  logic                          pv1_r, f1_r, run1_r;
  logic signed [COORD_WIDTH-1:0] x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (load1) begin
      pv1_r  <= in_pose_valid;
      x1_r   <= in_pos_x;
      y1_r   <= in_pos_y;
      z1_r   <= in_pos_z;
      f1_r   <= in_force_request;
      run1_r <= in_odometry_running;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: height window and the two products of each edge cross
  //   edge i runs from vertex i to vertex i+1; cross = ex*dy - ey*dx
  // ---------------------------------------------------------------------
  logic signed [PROD_WIDTH-1:0] p_nxt [NUM_EDGES];
  logic signed [PROD_WIDTH-1:0] q_nxt [NUM_EDGES];
  logic signed [PROD_WIDTH-1:0] p2_r  [NUM_EDGES];
  logic signed [PROD_WIDTH-1:0] q2_r  [NUM_EDGES];
  logic                         zout_nxt, zout2_r, f2_r, run2_r;

  always_comb begin
    logic signed [DIFF_WIDTH-1:0] ax, ay, bx, by, ex, ey, dx, dy;
    for (int i = 0; i < NUM_EDGES; i++) begin
      ax = DIFF_WIDTH'(signed'(vtx_r[i][VTX_WIDTH-1:COORD_WIDTH]));
      ay = DIFF_WIDTH'(signed'(vtx_r[i][COORD_WIDTH-1:0]));
      bx = DIFF_WIDTH'(signed'(vtx_r[(i + 1) % NUM_EDGES][VTX_WIDTH-1:COORD_WIDTH]));
      by = DIFF_WIDTH'(signed'(vtx_r[(i + 1) % NUM_EDGES][COORD_WIDTH-1:0]));
      ex = bx - ax;
      ey = by - ay;
      dx = DIFF_WIDTH'(x1_r) - ax;
      dy = DIFF_WIDTH'(y1_r) - ay;
      p_nxt[i] = PROD_WIDTH'(ex) * PROD_WIDTH'(dy);
      q_nxt[i] = PROD_WIDTH'(ey) * PROD_WIDTH'(dx);
    end
    zout_nxt = (z1_r < h_low_r) || (z1_r > h_high_r);
  end

  always_ff @(posedge clk) begin
    if (v1_r && free2) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        p2_r[i] <= p_nxt[i];
        q2_r[i] <= q_nxt[i];
      end
      zout2_r <= zout_nxt;
      pv2_r   <= pv1_r;
      f2_r    <= f1_r;
      run2_r  <= run1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (free1) begin
        v1_r <= in_valid;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: side test and monitor state update
  //   inside when all crosses are > 0 or all are <= 0 (zero: negative side)
  // ---------------------------------------------------------------------
  mode_t                  mode_r, mode_nxt;
  logic                   force_pending_r, force_pending_nxt;
  logic [COUNT_WIDTH-1:0] stop_elapsed_r, stop_elapsed_nxt;
  logic [COUNT_WIDTH-1:0] settle_count_r, settle_count_nxt;
  logic                   stop_nxt, start_nxt, outside_nxt;
  logic [NUM_EDGES-1:0]   pos_side;

  always_comb begin
    logic signed [CROSS_WIDTH-1:0] cross_val;
    for (int i = 0; i < NUM_EDGES; i++) begin
      cross_val   = CROSS_WIDTH'(p2_r[i]) - CROSS_WIDTH'(q2_r[i]);
      pos_side[i] = !cross_val[CROSS_WIDTH-1] && (cross_val != '0);
    end
    outside_nxt = zout2_r || !((&pos_side) || (pos_side == '0));
  end

  always_comb begin
    logic fp_eff;
    logic [COUNT_WIDTH-1:0] se_eff;
    // force latch and stop timer advance on every word
    fp_eff = force_pending_r || f2_r;
    se_eff = stop_elapsed_r;
    if (mode_r == MODE_OOB && stop_elapsed_r != COUNT_MAX) begin
      se_eff = stop_elapsed_r + COUNT_WIDTH'(1);
    end

    mode_nxt          = mode_r;
    force_pending_nxt = fp_eff;
    stop_elapsed_nxt  = se_eff;
    settle_count_nxt  = settle_count_r;
    stop_nxt          = 1'b0;
    start_nxt         = 1'b0;

    if (pv2_r) begin
      case (mode_r)
        MODE_ACTIVE: begin
          if (outside_nxt || fp_eff) begin
            force_pending_nxt = 1'b0;
            stop_elapsed_nxt  = '0;
            stop_nxt          = 1'b1;
            mode_nxt          = MODE_OOB;
          end
        end
        MODE_OOB: begin
          if (se_eff > stop_wait_r && !run2_r) begin
            start_nxt = 1'b1;
            mode_nxt  = MODE_RESTART;
          end
        end
        MODE_RESTART: begin
          if (settle_count_r < settle_wait_r) begin
            if (settle_count_r != COUNT_MAX) begin
              settle_count_nxt = settle_count_r + COUNT_WIDTH'(1);
            end
          end else begin
            settle_count_nxt = '0;
            if (outside_nxt) begin
              stop_nxt         = 1'b1;
              stop_elapsed_nxt = '0;
              mode_nxt         = MODE_OOB;
            end else begin
              mode_nxt = MODE_ACTIVE;
            end
          end
        end
        default: ; // unused code: hold
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_ACTIVE;
      force_pending_r <= 1'b0;
      stop_elapsed_r  <= '0;
      settle_count_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (take2) begin
        mode_r          <= mode_nxt;
        force_pending_r <= force_pending_nxt;
        stop_elapsed_r  <= stop_elapsed_nxt;
        settle_count_r  <= settle_count_nxt;
      end
      if (out_free) begin
        out_valid_r <= take2 && pv2_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  mode_t out_mode_r;
  logic  out_stop_r, out_start_r, out_outside_r;

  always_ff @(posedge clk) begin
    if (take2 && pv2_r) begin
      out_mode_r    <= mode_nxt;
      out_stop_r    <= stop_nxt;
      out_start_r   <= start_nxt;
      out_outside_r <= outside_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = out_mode_r;
  assign out_stop_odometry  = out_stop_r;
  assign out_start_odometry = out_start_r;
  assign out_outside        = out_outside_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_stop_odometry && out_start_odometry))
    else $error("stop and start pulse on the same result word");

  a_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_odometry) |-> (out_mode == MODE_RESTART))
    else $error("start pulse without entry to restarting");

  a_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_odometry) |-> (out_mode == MODE_OOB))
    else $error("stop pulse without entry to out of bounds");

  a_stop_timer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (take2 && pv2_r && stop_nxt) |=> (stop_elapsed_r == '0 && mode_r == MODE_OOB))
    else $error("stop timer not cleared on entry to out of bounds");

endmodule
